// ----- sv/wtkm_pkg.sv -----
// ----------------------------------------------------------------------------
// wtkm_pkg
// Shared constants, types and controller/datapath handshake structs for the
// winner tree k-way merge block.
// ----------------------------------------------------------------------------
package wtkm_pkg;

	// Leaf count of the tree; must be a power of two.
	localparam int MAX_SOURCES = 16;
	localparam int KEY_BITS    = 32;

	localparam int SRC_W   = $clog2(MAX_SOURCES);
	localparam int POS_W   = $clog2(2 * MAX_SOURCES);
	localparam int CNT_W   = $clog2(MAX_SOURCES + 1);
	localparam int NUM_W   = 5;
	localparam int NUM_RESET = 16;

	typedef logic [SRC_W-1:0]           src_t;
	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [POS_W-1:0]           pos_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [NUM_W-1:0]           num_t;

	// One tree value: a source index with its key, or none.
	typedef struct packed {
		logic valid;
		src_t src;
		key_t key;
	} node_t;

	typedef struct packed {
		logic start;   // capture accepted item, load leaf value
		logic step;    // move one level toward the root
		logic finish;  // load output register from the root
	} cmd_t;

	typedef struct packed {
		logic in_range;     // offered item addresses a configured source
		logic last_step;    // next step writes the root
		logic want_result;  // current item produces a result
	} status_t;

endpackage

// ----- sv/wtkm_if.sv -----
// ----------------------------------------------------------------------------
// wtkm_if
// Valid/ready channel interfaces: sorted input, merged result, config write.
// ----------------------------------------------------------------------------
interface wtkm_in_if;
	import wtkm_pkg::*;
	logic valid;
	logic ready;
	src_t source_index;
	key_t head_key;
	logic exhausted;
	modport source (output valid, source_index, head_key, exhausted, input ready);
	modport sink   (input valid, source_index, head_key, exhausted, output ready);
endinterface

interface wtkm_out_if;
	import wtkm_pkg::*;
	logic valid;
	logic ready;
	src_t winner_source;
	key_t winner_key;
	logic done_res;
	modport source (output valid, winner_source, winner_key, done_res, input ready);
	modport sink   (input valid, winner_source, winner_key, done_res, output ready);
endinterface

interface wtkm_cfg_if;
	import wtkm_pkg::*;
	logic valid;
	logic ready;
	num_t data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- sv/wtkm_datapath.sv -----
// ----------------------------------------------------------------------------
// wtkm_datapath
// Head keys, active flags, tree nodes and the leaf-to-root walk unit.
// ----------------------------------------------------------------------------
module wtkm_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  wtkm_pkg::cmd_t   cmd,
	output wtkm_pkg::status_t status,
	input  wtkm_pkg::src_t   in_source_index,
	input  wtkm_pkg::key_t   in_head_key,
	input  logic             in_exhausted,
	input  logic             cfg_we,
	input  wtkm_pkg::num_t   cfg_data,
	output wtkm_pkg::src_t   res_source,
	output wtkm_pkg::key_t   res_key,
	output logic             res_done
);
	import wtkm_pkg::*;

	num_t  num_q;
	cnt_t  eff;
	cnt_t  loaded_q;
	logic  merging_q;

	logic [MAX_SOURCES-1:0] active_q;
	key_t                   head_key_q [MAX_SOURCES];
	logic [MAX_SOURCES-1:0] node_valid_q;
	src_t                   node_src_q [MAX_SOURCES];
	key_t                   node_key_q [MAX_SOURCES];

	pos_t  pos_q;
	node_t path_q;

	pos_t  sib_pos;
	src_t  sib_idx;
	src_t  parent_idx;
	node_t sib;
	node_t left_n;
	node_t right_n;
	node_t win;
	logic  clear;

	// Zero acts as one, anything past the leaf count saturates.
	always_comb begin
		if (num_q == '0) begin
			eff = cnt_t'(1);
		end else if (int'(num_q) > MAX_SOURCES) begin
			eff = cnt_t'(MAX_SOURCES);
		end else begin
			eff = cnt_t'(num_q);
		end
	end

	assign status.in_range    = int'(in_source_index) < int'(eff);
	assign status.last_step   = (pos_q[POS_W-1:1] == src_t'(1));
	assign status.want_result = merging_q || (loaded_q >= eff);

	// Sibling on the current level: a leaf at the bottom, a stored node above.
	assign sib_pos    = pos_q ^ pos_t'(1);
	assign sib_idx    = sib_pos[SRC_W-1:0];
	assign parent_idx = pos_q[POS_W-1:1];

	always_comb begin
		if (pos_q[POS_W-1]) begin
			sib.valid = active_q[sib_idx];
			sib.src   = sib_idx;
			sib.key   = head_key_q[sib_idx];
		end else begin
			sib.valid = node_valid_q[sib_idx];
			sib.src   = node_src_q[sib_idx];
			sib.key   = node_key_q[sib_idx];
		end
	end

	// Ties go to the left child.
	always_comb begin
		if (pos_q[0]) begin
			left_n  = sib;
			right_n = path_q;
		end else begin
			left_n  = path_q;
			right_n = sib;
		end
		priority if (!left_n.valid) begin
			win = right_n;
		end else if (!right_n.valid) begin
			win = left_n;
		end else if ($signed(left_n.key) <= $signed(right_n.key)) begin
			win = left_n;
		end else begin
			win = right_n;
		end
	end

	// Drop the pass on a config write or when the merge runs dry.
	assign clear = cfg_we || (cmd.finish && !path_q.valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q        <= num_t'(NUM_RESET);
			loaded_q     <= '0;
			merging_q    <= 1'b0;
			active_q     <= '0;
			node_valid_q <= '0;
		end else begin
			if (cfg_we) begin
				num_q <= cfg_data;
			end
			if (clear) begin
				loaded_q     <= '0;
				merging_q    <= 1'b0;
				active_q     <= '0;
				node_valid_q <= '0;
			end else begin
				if (cmd.start && status.in_range) begin
					active_q[in_source_index] <= !in_exhausted;
					if (!merging_q) begin
						loaded_q <= loaded_q + cnt_t'(1);
					end
				end
				if (cmd.step) begin
					node_valid_q[parent_idx] <= win.valid;
				end
				if (cmd.finish) begin
					merging_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && status.in_range) begin
			if (!in_exhausted) begin
				head_key_q[in_source_index] <= in_head_key;
			end
			pos_q        <= pos_t'(MAX_SOURCES) + pos_t'(in_source_index);
			path_q.valid <= !in_exhausted;
			path_q.src   <= in_source_index;
			path_q.key   <= in_head_key;
		end else if (cmd.step) begin
			node_src_q[parent_idx] <= win.src;
			node_key_q[parent_idx] <= win.key;
			pos_q                  <= pos_t'(parent_idx);
			path_q                 <= win;
		end
		if (cmd.finish) begin
			if (path_q.valid) begin
				res_source <= path_q.src;
				res_key    <= path_q.key;
				res_done   <= 1'b0;
			end else begin
				res_source <= '0;
				res_key    <= '0;
				res_done   <= 1'b1;
			end
		end
	end

endmodule

// ----- sv/wtkm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wtkm_ctrl
// Sequencer: accept an item, walk the tree one level per cycle, emit.
// ----------------------------------------------------------------------------
module wtkm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output wtkm_pkg::cmd_t    cmd,
	input  wtkm_pkg::status_t status
);
	import wtkm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	assign cmd.start  = in_ready_q && in_valid;
	assign cmd.step   = (state_q == ST_WALK);
	assign cmd.finish = (state_q == ST_EMIT) && status.want_result && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result at finish, else hold until it is taken.
			out_valid_q <= cmd.finish || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start && status.in_range) begin
						state_q    <= ST_WALK;
						in_ready_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (status.last_step) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!status.want_result) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end else if (out_free) begin
						state_q     <= ST_IDLE;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/winner_tree_kway_merge_top.sv -----
// ----------------------------------------------------------------------------
// winner_tree_kway_merge_top
// K-way merge of sorted sources through a winner tree with a sequencer and
// a shared one-compare-per-level walk unit.
// ----------------------------------------------------------------------------
//
//  channel     dir  fields                                    transfer when
//  sorted_in   in   source_index, head_key, exhausted         valid && ready
//  merged_out  out  winner_source, winner_key, done_res       valid && ready
//  cfg         in   data (num_sources)                        valid && ready
//
//  An accepted item passes through the accept, one compare per tree level
//  (log2 MAX_SOURCES = 4 on the single walk unit) and an emit that may load
//  the output register. An item addressing an unconfigured source is dropped
//  in its accept cycle. Reset clears the active flags and node valid bits at
//  once; no clearing pass. A stalled result holds in the output register and
//  the next item is accepted meanwhile; it waits only in its emit cycle.
//
module winner_tree_kway_merge_top (
	input  logic  clk,
	input  logic  arst_n,
	wtkm_in_if.sink    sorted_in,
	wtkm_out_if.source merged_out,
	wtkm_cfg_if.sink   cfg
);
	import wtkm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Config is taken any time; the user must write it only while the block is idle, which the block does not enforce.
	assign cfg.ready = 1'b1;

	wtkm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sorted_in.valid),
		.in_ready  (sorted_in.ready),
		.out_valid (merged_out.valid),
		.out_ready (merged_out.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Every leaf write walks its path at once, so the tree is always current
	// and the build at the end of loading is just the last walk.
	wtkm_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_source_index (sorted_in.source_index),
		.in_head_key     (sorted_in.head_key),
		.in_exhausted    (sorted_in.exhausted),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.data),
		.res_source      (merged_out.winner_source),
		.res_key         (merged_out.winner_key),
		.res_done        (merged_out.done_res)
	);

endmodule

// ----- sv/wtkm_checker.sv -----
// ----------------------------------------------------------------------------
// wtkm_checker
// Port-level checks of the merge block, bound to the top level.
// ----------------------------------------------------------------------------
module wtkm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input wtkm_pkg::src_t out_source,
	input wtkm_pkg::key_t out_key,
	input logic           out_done
);
	import wtkm_pkg::*;

	logic in_xfer;
	assign in_xfer = in_valid && in_ready;

	// Hold a result until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A walk that starts blocks new input through its four levels and the emit.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> !in_ready [*5])
		else $error("input taken during tree walk");

	// A result never appears right after a transfer.
	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_xfer))
		else $error("result earlier than the walk allows");

	// Done carries a zero source and key.
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_done |-> (out_source == '0) && (out_key == '0))
		else $error("done result with nonzero payload");

endmodule

bind winner_tree_kway_merge_top wtkm_checker u_wtkm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sorted_in.valid),
	.in_ready   (sorted_in.ready),
	.out_valid  (merged_out.valid),
	.out_ready  (merged_out.ready),
	.out_source (merged_out.winner_source),
	.out_key    (merged_out.winner_key),
	.out_done   (merged_out.done_res)
);

// ----- sim/winner_tree_kway_merge_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winner_tree_kway_merge_top_test
// Self-checking bench for the winner tree merge. A driver pulls loads, refills,
// config writes and drain points from a pending queue. A monitor matches each
// emitted winner against a shadow tree that is updated at every input transfer.
// ----------------------------------------------------------------------------
module winner_tree_kway_merge_top_test;
	import wtkm_pkg::*;

	localparam int   NONE   = MAX_SOURCES;   // empty tree slot
	localparam int   SETTLE = 12;            // quiet cycles before a config write
	localparam key_t KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
	localparam key_t KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};

	typedef enum {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_t;

	typedef struct {
		act_kind_t act;
		src_t src;
		key_t key;
		logic ex;
		num_t num;
	} act_t;

	typedef struct packed {
		src_t src;
		key_t key;
		logic done;
	} res_t;

	logic clk;
	logic arst_n;

	wtkm_in_if  sorted_in ();
	wtkm_out_if merged_out ();
	wtkm_cfg_if cfg ();

	winner_tree_kway_merge_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.sorted_in  (sorted_in),
		.merged_out (merged_out),
		.cfg        (cfg)
	);

	// Pending stimulus and the winners still owed by the block.
	act_t todo_q[$];
	res_t winners_due[$];

	int   due_cnt;          // winners predicted (updated at the clock edge)
	int   seen_cnt;         // winners matched (updated at the clock edge)
	int   fails;
	int   accepted;
	int   quiet;            // cycles since the last transfer on the sender side
	int   gap;              // sender idle cycles still to insert
	logic calm;             // last stretch of the run: no idling on either side

	// Generator bookkeeping
	int   gen_span;
	int   counted;
	int   passes;
	int   cfg_writes;
	bit   clean;

	// Shadow tree
	num_t cfg_num;
	key_t heads [MAX_SOURCES];
	logic live  [MAX_SOURCES];
	int   tree  [MAX_SOURCES];
	int   loaded;
	logic merging;

	// ------------------------------------------------------------------
	// Shadow tree of the block
	// ------------------------------------------------------------------
	function automatic int span();
		if (cfg_num == 0) return 1;
		if (cfg_num > MAX_SOURCES) return MAX_SOURCES;
		return int'(cfg_num);
	endfunction

	function automatic int slot_value(int p);
		if (p >= MAX_SOURCES) begin
			if (p - MAX_SOURCES < span() && live[p - MAX_SOURCES]) return p - MAX_SOURCES;
			return NONE;
		end
		return tree[p];
	endfunction

	// Lower key wins; ties go to the left (lower) source.
	function automatic int pick_lower(int a, int b);
		if (a == NONE) return b;
		if (b == NONE) return a;
		return (heads[a] <= heads[b]) ? a : b;
	endfunction

	function automatic void clear_pass();
		for (int i = 0; i < MAX_SOURCES; i++) begin
			live[i] = 1'b0;
			tree[i] = NONE;
		end
		loaded = 0;
		merging = 1'b0;
	endfunction

	function automatic void load_num(num_t v);
		cfg_num = v;
		clear_pass();
	endfunction

	// Apply one accepted item; return 1 and the winner when it emits one.
	function automatic bit tree_advance(src_t s, key_t k, logic ex, output res_t r);
		int p;
		r = '0;
		if (int'(s) >= span()) return 1'b0;
		live[s] = !ex;
		if (!ex) heads[s] = k;
		if (!merging) begin
			if (loaded < 31) loaded++;
			if (loaded < span()) return 1'b0;
			for (p = MAX_SOURCES - 1; p >= 1; p--)
				tree[p] = pick_lower(slot_value(2 * p), slot_value(2 * p + 1));
		end else begin
			p = MAX_SOURCES + int'(s);
			while (p > 1) begin
				p = p / 2;
				tree[p] = pick_lower(slot_value(2 * p), slot_value(2 * p + 1));
			end
		end
		if (tree[1] == NONE) begin
			r.done = 1'b1;
			clear_pass();
		end else begin
			r.src = src_t'(tree[1]);
			r.key = heads[tree[1]];
			merging = 1'b1;
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic key_t rand_key();
		return key_t'($urandom);
	endfunction

	task automatic queue_item(int s, key_t k, logic ex);
		act_t a;
		a.act = ACT_ITEM;
		a.src = src_t'(s);
		a.key = k;
		a.ex  = ex;
		a.num = '0;
		todo_q.push_back(a);
		if (s < gen_span) counted++;
	endtask

	task automatic queue_pause();
		act_t a;
		a = '{ACT_DRAIN, '0, '0, 1'b0, '0};
		todo_q.push_back(a);
	endtask

	task automatic queue_cfg(int v);
		act_t a;
		a = '{ACT_CFG, '0, '0, 1'b0, num_t'(v)};
		todo_q.push_back(a);
		gen_span = (v < 1) ? 1 : (v > MAX_SOURCES) ? MAX_SOURCES : v;
		cfg_writes++;
		clean = 1'b1;
	endtask

	// One merge pass over n sorted sources: load all heads in random order,
	// then keep refilling the current winner, with some noise mixed in.
	task automatic queue_pass(int n, bit narrow, bit abort);
		key_t   keys  [MAX_SOURCES][8];
		int     len   [MAX_SOURCES];
		int     pos   [MAX_SOURCES];
		int     order [MAX_SOURCES];
		key_t   head  [MAX_SOURCES];
		bit     alive [MAX_SOURCES];
		longint v;
		int     i, j, t, w, steps, abort_at;
		key_t   k;
		logic   ex;
		abort_at = abort ? $urandom_range(1, 12) : -1;
		for (i = 0; i < n; i++) begin
			len[i] = $urandom_range(0, 7);
			pos[i] = 0;
			if (narrow)
				v = longint'($urandom_range(0, 8)) - 4;
			else case ($urandom_range(0, 3))
				0:       v = longint'(KEY_MIN);
				1:       v = longint'($signed($urandom));
				default: v = longint'($signed($urandom)) / 256;
			endcase
			for (j = 0; j < len[i]; j++) begin
				keys[i][j] = key_t'(v);
				v += narrow ? $urandom_range(0, 2) : $urandom_range(0, 1 << 26);
				if (v > longint'(KEY_MAX)) v = longint'(KEY_MAX);
			end
			if (len[i] != 0 && $urandom_range(0, 7) == 0) keys[i][len[i] - 1] = KEY_MAX;
			order[i] = i;
		end
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		// loading: exhausted sources carry a random key that must be ignored
		for (i = 0; i < n; i++) begin
			t = order[i];
			alive[t] = (len[t] != 0);
			if (alive[t]) begin
				head[t] = keys[t][0];
				pos[t] = 1;
				queue_item(t, head[t], 1'b0);
			end else
				queue_item(t, rand_key(), 1'b1);
		end
		// merging: refill whoever holds the smallest head
		steps = 0;
		clean = 1'b1;
		while (steps < 200) begin
			w = -1;
			for (i = 0; i < n; i++)
				if (alive[i] && (w < 0 || head[i] < head[w])) w = i;
			if (w < 0) break;
			if (steps == abort_at) begin
				clean = 1'b0;
				break;
			end
			if ($urandom_range(0, 9) == 0) begin
				t = $urandom_range(0, MAX_SOURCES - 1);
				ex = ($urandom_range(0, 3) == 0);
				k = rand_key();
				queue_item(t, k, ex);
				if (t < n) begin
					alive[t] = !ex;
					head[t] = k;
					if (ex) pos[t] = len[t];
				end
			end else if (pos[w] < len[w]) begin
				head[w] = keys[w][pos[w]];
				pos[w]++;
				queue_item(w, head[w], 1'b0);
			end else begin
				alive[w] = 1'b0;
				queue_item(w, rand_key(), 1'b1);
			end
			steps++;
			if ($urandom_range(0, 39) == 0) queue_pause();
		end
		if (steps >= 200) clean = 1'b0;
		passes++;
	endtask

	// ------------------------------------------------------------------
	// Clock and watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("%0t: timeout, %0d winners still owed", $time, due_cnt - seen_cnt);
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: advance the pending queue, one transfer at a time.
	// Predict at the input transfer; hold config writes and drain points
	// until the block has been quiet and every owed winner has come out.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : driver
		res_t won;
		act_t nxt;
		logic in_v, cfg_v, pushed;
		src_t n_src;
		key_t n_key;
		logic n_ex;
		num_t n_num;
		bit   settled;
		in_v   = sorted_in.valid;
		cfg_v  = cfg.valid;
		n_src  = sorted_in.source_index;
		n_key  = sorted_in.head_key;
		n_ex   = sorted_in.exhausted;
		n_num  = cfg.data;
		pushed = 1'b0;
		if (arst_n) begin
			settled = (due_cnt == seen_cnt) && !in_v && !cfg_v && quiet >= SETTLE;
			if (in_v && sorted_in.ready) begin
				accepted++;
				if (tree_advance(n_src, n_key, n_ex, won)) begin
					winners_due.push_back(won);
					pushed = 1'b1;
				end
				in_v = 1'b0;
				quiet = 0;
				// start an idle burst now and then
				if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
			end else if (quiet < SETTLE)
				quiet++;
			if (cfg_v && cfg.ready) begin
				load_num(n_num);
				cfg_v = 1'b0;
				quiet = 0;
			end
			if (!in_v && !cfg_v && todo_q.size() != 0) begin
				nxt = todo_q[0];
				case (nxt.act)
					ACT_ITEM: begin
						if (gap != 0)
							gap--;
						else begin
							nxt = todo_q.pop_front();
							in_v  = 1'b1;
							n_src = nxt.src;
							n_key = nxt.key;
							n_ex  = nxt.ex;
						end
					end
					default: begin
						if (settled) begin
							nxt = todo_q.pop_front();
							if (nxt.act == ACT_CFG) begin
								cfg_v = 1'b1;
								n_num = nxt.num;
							end
						end
					end
				endcase
			end
		end
		sorted_in.valid        <= in_v;
		sorted_in.source_index <= n_src;
		sorted_in.head_key     <= n_key;
		sorted_in.exhausted    <= n_ex;
		cfg.valid              <= cfg_v;
		cfg.data               <= n_num;
		due_cnt                <= due_cnt + (pushed ? 1 : 0);
		calm                   <= (todo_q.size() < 50);
	end

	// ------------------------------------------------------------------
	// Receiver back-pressure: random stall bursts, plus one long hold-off
	// that lets the block fill up and stall its input.
	// ------------------------------------------------------------------
	int stall_left;
	bit long_hold_done;

	always @(posedge clk) begin : receiver
		if (arst_n) begin
			if (stall_left != 0)
				stall_left--;
			else if (!long_hold_done && seen_cnt >= 120) begin
				stall_left = 400;
				long_hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 16);
		end
		merged_out.ready <= arst_n && (stall_left == 0);
	end

	// ------------------------------------------------------------------
	// Monitor: compare every winner transfer against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n && merged_out.valid && merged_out.ready) begin
			if (winners_due.size() == 0) begin
				$display("%0t: unexpected winner, expected none, %s",
					$time, "got:");
				$display("    src=%0d key=%0d done=%0b",
					merged_out.winner_source, merged_out.winner_key,
					merged_out.done_res);
				fails++;
			end else begin
				want = winners_due.pop_front();
				if (merged_out.winner_source !== want.src
					|| merged_out.winner_key !== want.key
					|| merged_out.done_res !== want.done) begin
					$display("%0t: winner mismatch, expected src=%0d key=%0d done=%0b,",
						$time, want.src, want.key, want.done);
					$display("    got src=%0d key=%0d done=%0b",
						merged_out.winner_source, merged_out.winner_key,
						merged_out.done_res);
					fails++;
				end
				seen_cnt <= seen_cnt + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Run: reset, fill the pending queue, wait for the drain, report
	// ------------------------------------------------------------------
	initial begin : run
		int num;
		arst_n = 1'b0;
		sorted_in.valid = 1'b0;
		sorted_in.source_index = '0;
		sorted_in.head_key = '0;
		sorted_in.exhausted = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		merged_out.ready = 1'b0;
		due_cnt = 0;
		seen_cnt = 0;
		fails = 0;
		accepted = 0;
		quiet = 0;
		gap = 0;
		calm = 1'b0;
		stall_left = 0;
		long_hold_done = 1'b0;
		passes = 0;
		cfg_writes = 0;
		counted = 0;
		gen_span = NUM_RESET;
		clean = 1'b1;
		for (int i = 0; i < MAX_SOURCES; i++) heads[i] = '0;
		load_num(num_t'(NUM_RESET));

		// Directed: three sources with extreme keys, ties, a dropped
		// out-of-range item, reactivation of an exhausted source, and done.
		queue_cfg(3);
		queue_item(0, KEY_MAX, 1'b0);
		queue_item(2, -1, 1'b1);
		queue_item(1, KEY_MIN, 1'b0);
		queue_item(1, -5, 1'b0);
		queue_item(1, KEY_MAX, 1'b0);
		queue_item(5, 0, 1'b0);
		queue_item(0, 0, 1'b1);
		queue_item(2, 0, 1'b0);
		queue_item(2, 0, 1'b1);
		queue_item(1, 0, 1'b1);
		// zero sources acts as one; an exhausted-only load ends at once
		queue_cfg(0);
		queue_item(1, 3, 1'b0);
		queue_item(0, -1, 1'b0);
		queue_item(0, 7, 1'b1);
		queue_item(0, 9, 1'b1);
		// loading one source twice completes the load
		queue_cfg(2);
		queue_item(0, 10, 1'b0);
		queue_item(0, 3, 1'b0);
		queue_item(0, 0, 1'b1);
		// abort a half-loaded pass with a config write that saturates
		queue_item(1, 1, 1'b0);
		queue_cfg(31);

		// Random passes; most are well-formed merges with random content.
		counted = 0;
		while (counted < 480) begin
			case ($urandom_range(0, 9))
				0:       num = 0;
				1:       num = 31;
				2:       num = MAX_SOURCES;
				3:       num = 1;
				4:       num = $urandom_range(MAX_SOURCES + 1, 30);
				default: num = $urandom_range(2, MAX_SOURCES - 1);
			endcase
			// after a clean done the block is back in loading: reuse it as is
			if (!clean || $urandom_range(0, 2) != 0) queue_cfg(num);
			queue_pass(gen_span, $urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (todo_q.size() != 0 || sorted_in.valid || cfg.valid || due_cnt != seen_cnt);
		repeat (20) @(negedge clk);

		if (winners_due.size() != 0) begin
			$display("%0t: %0d predicted winners never came out", $time, winners_due.size());
			fails += winners_due.size();
		end
		$display("Ran %0d merge passes with %0d source-count writes, zero and saturating ones too.",
			passes, cfg_writes);
		$display("Sent %0d items and matched %0d winners under random and long output stalls.",
			accepted, seen_cnt);
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
